>>> src/stree_pkg.sv
// shared types and constants for the segment tree range sum block
package stree_pkg;

  // fixed field widths
  localparam int FIELD_W = 11;
  localparam int DATA_W  = 32;

  // request opcodes
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF,
    ST_SRD,
    ST_SWR,
    ST_QLEFT,
    ST_QRIGHT,
    ST_QDONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic leaf_wr;
    logic sib_rd;
    logic par_wr;
    logic ql_step;
    logic qr_step;
    logic clr_step;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_e  op;
    logic pos_ok;
    logic q_empty;
    logic i_gt1;
    logic l_lt_r;
    logic clr_last;
  } status_t;

endpackage

>>> src/stree_ram.sv
// generic simple dual port ram with registered read
module stree_ram #(
  parameter int W = 32,
  parameter int D = 2048
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/stree_dp.sv
// datapath: node store, index registers, accumulator and result register
module stree_dp #(
  parameter int LEAVES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stree_pkg::cmd_t               cmd_i,
  output stree_pkg::status_t            status_o,
  input  logic [1:0]                    opcode_i,
  input  logic [stree_pkg::FIELD_W-1:0] position_i,
  input  logic [stree_pkg::DATA_W-1:0]  value_i,
  input  logic [stree_pkg::FIELD_W-1:0] range_low_i,
  input  logic [stree_pkg::FIELD_W-1:0] range_high_i,
  output logic [stree_pkg::DATA_W-1:0]  range_sum_o
);
  import stree_pkg::*;

  localparam int AW = $clog2(2 * LEAVES);
  localparam int NW = $clog2(2 * LEAVES + 1);
  localparam int CW = (NW > FIELD_W) ? NW : FIELD_W;

  logic [NW-1:0]     node_i_q, node_i_d;
  logic [NW-1:0]     node_l_q, node_l_d;
  logic [NW-1:0]     node_r_q, node_r_d;
  logic [DATA_W-1:0] cur_q, cur_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] sum_q;
  logic [AW-1:0]     clr_q, clr_d;
  logic              rd_pend_q;

  logic [CW-1:0]     ext_pos, lo_c, hi_c;
  logic [CW-1:0]     leaf_i, leaf_l, leaf_r;
  logic [NW-1:0]     par_idx, sib_idx, r_dec;
  logic [DATA_W-1:0] rdata, par_sum;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata;

  // request decode and range clipping
  always_comb begin
    ext_pos = CW'(position_i);
    lo_c    = (range_low_i == '0) ? CW'(1) : CW'(range_low_i);
    hi_c    = (CW'(range_high_i) > CW'(LEAVES)) ? CW'(LEAVES) : CW'(range_high_i);
    leaf_i  = CW'(LEAVES) + ext_pos - CW'(1);
    leaf_l  = CW'(LEAVES) + lo_c - CW'(1);
    leaf_r  = CW'(LEAVES) + hi_c;
  end

  // node address helpers
  assign par_idx = node_i_q >> 1;
  assign sib_idx = node_i_q ^ NW'(1);
  assign r_dec   = node_r_q - NW'(1);
  assign par_sum = cur_q + rdata;

  // status towards the controller
  always_comb begin
    status_o.op       = op_e'(opcode_i);
    status_o.pos_ok   = (position_i != '0) && (ext_pos <= CW'(LEAVES));
    status_o.q_empty  = lo_c > hi_c;
    status_o.i_gt1    = node_i_q > NW'(1);
    status_o.l_lt_r   = node_l_q < node_r_q;
    status_o.clr_last = clr_q == AW'(2 * LEAVES - 1);
  end

  // node store port control
  always_comb begin
    ram_we    = cmd_i.leaf_wr | cmd_i.par_wr | cmd_i.clr_step;
    ram_waddr = par_idx[AW-1:0];
    ram_wdata = par_sum;
    if (cmd_i.clr_step) begin
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (cmd_i.leaf_wr) begin
      ram_waddr = node_i_q[AW-1:0];
      ram_wdata = cur_q;
    end
    ram_re    = cmd_i.sib_rd | (cmd_i.ql_step & node_l_q[0]) | (cmd_i.qr_step & node_r_q[0]);
    ram_raddr = r_dec[AW-1:0];
    if (cmd_i.sib_rd) begin
      ram_raddr = sib_idx[AW-1:0];
    end else if (cmd_i.ql_step) begin
      ram_raddr = node_l_q[AW-1:0];
    end
  end

  stree_ram #(
    .W (DATA_W),
    .D (2 * LEAVES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // index, running value and accumulator updates
  always_comb begin
    node_i_d = node_i_q;
    node_l_d = node_l_q;
    node_r_d = node_r_q;
    cur_d    = cur_q;
    acc_d    = rd_pend_q ? (acc_q + rdata) : acc_q;
    if (cmd_i.load) begin
      node_i_d = leaf_i[NW-1:0];
      node_l_d = leaf_l[NW-1:0];
      node_r_d = leaf_r[NW-1:0];
      cur_d    = value_i;
      acc_d    = '0;
    end
    if (cmd_i.par_wr) begin
      node_i_d = par_idx;
      cur_d    = par_sum;
    end
    if (cmd_i.ql_step && node_l_q[0]) begin
      node_l_d = node_l_q + NW'(1);
    end
    if (cmd_i.qr_step) begin
      node_l_d = node_l_q >> 1;
      node_r_d = node_r_q >> 1;
    end
  end

  // clearing sweep counter
  always_comb begin
    clr_d = clr_q;
    if (cmd_i.clr_step) begin
      clr_d = status_o.clr_last ? '0 : clr_q + AW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      rd_pend_q <= ram_re;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    node_i_q <= node_i_d;
    node_l_q <= node_l_d;
    node_r_q <= node_r_d;
    cur_q    <= cur_d;
    acc_q    <= acc_d;
    if (cmd_i.out_load) begin
      sum_q <= acc_q;
    end
  end

  assign range_sum_o = sum_q;

endmodule

>>> src/stree_ctrl.sv
// controller state machine sequencing set, query and clear requests
module stree_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_stall_i,
  input  stree_pkg::status_t status_i,
  output stree_pkg::cmd_t    cmd_o,
  output logic               in_stall_o,
  output logic               out_valid_o
);
  import stree_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // result register can take a new value
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (status_i.op)
            OP_SET:   state_d = status_i.pos_ok ? ST_LEAF : ST_IDLE;
            OP_QUERY: state_d = status_i.q_empty ? ST_QDONE : ST_QLEFT;
            OP_CLEAR: state_d = ST_CLEAR;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_LEAF:   state_d = ST_SRD;
      ST_SRD:    state_d = status_i.i_gt1 ? ST_SWR : ST_IDLE;
      ST_SWR:    state_d = ST_SRD;
      ST_QLEFT:  state_d = status_i.l_lt_r ? ST_QRIGHT : ST_QDONE;
      ST_QRIGHT: state_d = ST_QLEFT;
      ST_QDONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // commands and handshake outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.leaf_wr  = state_q == ST_LEAF;
    cmd_o.sib_rd   = (state_q == ST_SRD) && status_i.i_gt1;
    cmd_o.par_wr   = state_q == ST_SWR;
    cmd_o.ql_step  = (state_q == ST_QLEFT) && status_i.l_lt_r;
    cmd_o.qr_step  = state_q == ST_QRIGHT;
    cmd_o.clr_step = state_q == ST_CLEAR;
    cmd_o.out_load = (state_q == ST_QDONE) && out_free;
    out_valid_d    = cmd_o.out_load || (out_valid_q && out_stall_i);
    in_stall_o     = state_q != ST_IDLE;
  end

  // state registers, sweep of the store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/segment_tree_range_sum_top.sv
// top level of the segment tree range sum block
//
//   channel  direction  handshake             payload
//   in       in         in_valid_i/in_stall_o   opcode, position, value, range_low, range_high
//   out      out        out_valid_o/out_stall_i range_sum
//
// one request at a time; the single read port of the node store sets the pace
// set: write the leaf, then read the sibling and write the parent per level
// query: one left step and one right step per tree level walked, then load the result
// clear, and the sweep after reset: zero all 2*LEAVES nodes with in_stall_o high
// a stalled result sits in the output register; a new request is taken meanwhile
module segment_tree_range_sum_top #(
  parameter int LEAVES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [stree_pkg::FIELD_W-1:0] position_i,
  input  logic signed [stree_pkg::DATA_W-1:0] value_i,
  input  logic [stree_pkg::FIELD_W-1:0] range_low_i,
  input  logic [stree_pkg::FIELD_W-1:0] range_high_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [stree_pkg::DATA_W-1:0] range_sum_o
);
  import stree_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [DATA_W-1:0] sum;

  stree_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  stree_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .opcode_i     (opcode_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .range_sum_o  (sum)
  );

  assign range_sum_o = sum;

endmodule

>>> src/stree_chk.sv
// port level checker for the segment tree range sum block, with its bind
module stree_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [1:0]                    opcode_i,
  input logic [stree_pkg::FIELD_W-1:0] position_i,
  input logic [stree_pkg::DATA_W-1:0]  value_i,
  input logic [stree_pkg::FIELD_W-1:0] range_low_i,
  input logic [stree_pkg::FIELD_W-1:0] range_high_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [stree_pkg::DATA_W-1:0]  range_sum_o
);
  import stree_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(range_sum_o))
    else $error("stalled result changed or dropped");

  // store sweep keeps requests out right after reset
  a_reset_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("request taken during store sweep");

  // query and clear keep the block busy in the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_QUERY || opcode_i == OP_CLEAR) |=> in_stall_o)
    else $error("block idle right after a query or clear request");

  // no result can show in the cycle after a request is taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind segment_tree_range_sum_top stree_chk u_chk (.*);
